### hw/rtl/topic_chain_forward_backward_assert.svh
// Assertion macros for the topic chain forward-backward block
`ifndef TOPIC_CHAIN_FORWARD_BACKWARD_ASSERT_SVH
`define TOPIC_CHAIN_FORWARD_BACKWARD_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TCFB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcfb check failed");
// next-cycle implication
`define TCFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcfb check failed");
`endif

### hw/rtl/tcfb_pkg.sv
// Package: widths, constants, log(1+exp) table and saturation helpers
package tcfb_pkg;
    localparam int TOPICS    = 8;
    localparam int MAX_WORDS = 64;
    localparam int FRAC_BITS = 10;
    localparam int LANES     = 8;
    localparam int WORD_W    = 6;
    localparam int CNT_W     = 7;
    localparam int TOP_W     = 3;
    localparam int ADDR_W    = WORD_W + TOP_W;
    localparam int LUT_LAST  = 48;
    localparam logic signed [33:0] CUTOFF = 34'sd6 <<< FRAC_BITS;

    localparam logic [1:0] REG_TOPICS = 2'd0;
    localparam logic [1:0] REG_SWITCH = 2'd1;
    localparam logic [1:0] REG_STAY   = 2'd2;

    typedef logic signed [31:0] val_t;

    function automatic logic [15:0] lut_q16(input logic [5:0] idx);
        logic [15:0] r;
        case (idx)
            6'd0: r = 16'd45426;  6'd1: r = 16'd41453;  6'd2: r = 16'd37745;
            6'd3: r = 16'd34285;  6'd4: r = 16'd31069;  6'd5: r = 16'd28095;
            6'd6: r = 16'd25354;  6'd7: r = 16'd22836;  6'd8: r = 16'd20530;
            6'd9: r = 16'd18425;  6'd10: r = 16'd16510; 6'd11: r = 16'd14773;
            6'd12: r = 16'd13200; 6'd13: r = 16'd11780; 6'd14: r = 16'd10500;
            6'd15: r = 16'd9350;  6'd16: r = 16'd8318;  6'd17: r = 16'd7394;
            6'd18: r = 16'd6567;  6'd19: r = 16'd5829;  6'd20: r = 16'd5170;
            6'd21: r = 16'd4583;  6'd22: r = 16'd4061;  6'd23: r = 16'd3597;
            6'd24: r = 16'd3184;  6'd25: r = 16'd2818;  6'd26: r = 16'd2493;
            6'd27: r = 16'd2205;  6'd28: r = 16'd1950;  6'd29: r = 16'd1724;
            6'd30: r = 16'd1523;  6'd31: r = 16'd1346;  6'd32: r = 16'd1189;
            6'd33: r = 16'd1051;  6'd34: r = 16'd928;   6'd35: r = 16'd820;
            6'd36: r = 16'd724;   6'd37: r = 16'd639;   6'd38: r = 16'd565;
            6'd39: r = 16'd498;   6'd40: r = 16'd440;   6'd41: r = 16'd389;
            6'd42: r = 16'd343;   6'd43: r = 16'd303;   6'd44: r = 16'd267;
            6'd45: r = 16'd236;   6'd46: r = 16'd208;   6'd47: r = 16'd184;
            default: r = 16'd162;
        endcase
        return r;
    endfunction

    function automatic val_t sat32(input logic signed [33:0] v);
        val_t r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturating add of two 32-bit values
    function automatic val_t sadd(input val_t a, input val_t b);
        return sat32(34'(a) + 34'(b));
    endfunction

    // saturating sum of three values, one saturation at the end
    function automatic val_t sadd3(input val_t a, input val_t b, input val_t c);
        return sat32(34'(a) + 34'(b) + 34'(c));
    endfunction
endpackage

### hw/rtl/tcfb_if.sv
// Valid/ready channel interfaces for input and result beats
interface tcfb_in_if
    import tcfb_pkg::*;
();
    logic valid;
    logic ready;
    logic opcode;
    val_t topic_value_0, topic_value_1, topic_value_2, topic_value_3;
    val_t topic_value_4, topic_value_5, topic_value_6, topic_value_7;
    logic last_word;
    modport source (output valid, opcode, topic_value_0, topic_value_1, topic_value_2,
                    topic_value_3, topic_value_4, topic_value_5, topic_value_6,
                    topic_value_7, last_word, input ready);
    modport sink (input valid, opcode, topic_value_0, topic_value_1, topic_value_2,
                  topic_value_3, topic_value_4, topic_value_5, topic_value_6,
                  topic_value_7, last_word, output ready);
endinterface

interface tcfb_out_if
    import tcfb_pkg::*;
();
    logic valid;
    logic ready;
    logic [WORD_W-1:0] word_position;
    val_t posterior_0, posterior_1, posterior_2, posterior_3;
    val_t posterior_4, posterior_5, posterior_6, posterior_7;
    logic [TOP_W-1:0] best_topic;
    logic final_result;
    modport source (output valid, word_position, posterior_0, posterior_1, posterior_2,
                    posterior_3, posterior_4, posterior_5, posterior_6, posterior_7,
                    best_topic, final_result, input ready);
    modport sink (input valid, word_position, posterior_0, posterior_1, posterior_2,
                  posterior_3, posterior_4, posterior_5, posterior_6, posterior_7,
                  best_topic, final_result, output ready);
endinterface

### hw/rtl/topic_chain_forward_backward.sv
// Top level: topic chain forward-backward over a sticky topic chain
//
//  channel | dir | beat content
//  in_ch   | in  | prior or word emission values, last mark
//  out_ch  | out | word position, 8 log posteriors, best topic, last mark
//  cfg     | in  | topic count, log switch weight, log stay extra
//
// Prior and non-last word beats are taken whenever the block is idle.
// After the last word one log-add unit is reused: each message step loads each
// topic (LOAD2, LOAD), folds (SUM) and writes (MSG); each sweep opens by zeroing
// its boundary row (INIT), then forward and backward run (n-1) steps each; each
// posterior loads, folds and normalizes (POST) per topic, plus its output beat.
// Input is not ready from the last word until the final result is taken.
// Reset (rst_n low, async) returns to idle with default register values.
module topic_chain_forward_backward
    import tcfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    tcfb_in_if.sink     in_ch,
    tcfb_out_if.source  out_ch
);
    val_t in_val [LANES];
    val_t post   [LANES];

    assign in_val[0] = in_ch.topic_value_0;
    assign in_val[1] = in_ch.topic_value_1;
    assign in_val[2] = in_ch.topic_value_2;
    assign in_val[3] = in_ch.topic_value_3;
    assign in_val[4] = in_ch.topic_value_4;
    assign in_val[5] = in_ch.topic_value_5;
    assign in_val[6] = in_ch.topic_value_6;
    assign in_val[7] = in_ch.topic_value_7;

    tcfb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_opcode (in_ch.opcode),
        .in_val    (in_val),
        .in_last   (in_ch.last_word),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_pos   (out_ch.word_position),
        .out_post  (post),
        .out_best  (out_ch.best_topic),
        .out_final (out_ch.final_result)
    );

    assign out_ch.posterior_0 = post[0];
    assign out_ch.posterior_1 = post[1];
    assign out_ch.posterior_2 = post[2];
    assign out_ch.posterior_3 = post[3];
    assign out_ch.posterior_4 = post[4];
    assign out_ch.posterior_5 = post[5];
    assign out_ch.posterior_6 = post[6];
    assign out_ch.posterior_7 = post[7];
endmodule

### hw/rtl/tcfb_logadd.sv
// Shared log-add unit: a-b difference, cutoff compare, table correction, saturating sum
module tcfb_logadd
    import tcfb_pkg::*;
(
    input  val_t a,
    input  val_t b,
    output val_t y
);
    logic signed [33:0] d;
    logic signed [33:0] ad;
    logic [26:0]        idx_raw;
    logic [5:0]         idx;
    logic [31:0]        corr;
    val_t               mx;

    always_comb
    begin
        d       = 34'(a) - 34'(b);
        ad      = (d < 0) ? -d : d;
        idx_raw = ad[FRAC_BITS-3 +: 27];
        idx     = (idx_raw > 27'(LUT_LAST)) ? 6'(LUT_LAST) : idx_raw[5:0];
        corr    = ((32'(lut_q16(idx)) << FRAC_BITS) + 32'd32768) >> 16;
        mx      = (a >= b) ? a : b;
        if (d > CUTOFF)
            y = a;
        else if (-d > CUTOFF)
            y = b;
        else
            y = sat32(34'(mx) + 34'($signed({1'b0, corr})));
    end
endmodule

### hw/rtl/tcfb_core.sv
// Sequencer: stores, forward/backward sweeps and posterior output
module tcfb_core
    import tcfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_opcode,
    input  val_t                in_val [LANES],
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   out_pos,
    output val_t                out_post [LANES],
    output logic [TOP_W-1:0]    out_best,
    output logic                out_final
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,  // read factor/message of one topic
        ST_SUM   = 8'b0000_0100,  // fold S (or logsum) one topic per cycle
        ST_MSG   = 8'b0000_1000,  // write m[k] one topic per cycle
        ST_POST  = 8'b0001_0000,  // posterior differences and argmax
        ST_OUT   = 8'b0010_0000,
        ST_INIT  = 8'b0100_0000,  // zero the first forward / last backward row
        ST_LOAD2 = 8'b1000_0000   // read data wait
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]        ktop_reg;
    logic signed [16:0] sw_reg, st_reg;

    val_t prior_reg [LANES];
    // one row per word, lane t in bits 32t+31..32t
    logic [LANES*32-1:0] emis_mem [MAX_WORDS];
    val_t fwd_mem   [MAX_WORDS*LANES];
    val_t bwd_mem   [MAX_WORDS*LANES];

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  n_reg;
    logic              back_reg;   // phase: 0 fwd, 1 bwd
    logic              post_reg;   // posterior pass
    logic [WORD_W-1:0] j_reg;      // source word of current step
    logic [TOP_W-1:0]  i_reg;
    val_t              x_reg [LANES];
    val_t              s_reg;
    val_t              best_val_reg;
    logic [TOP_W-1:0]  best_reg;
    val_t              post_reg_v [LANES];
    logic [LANES*32-1:0] e_row_reg;
    val_t              f_rd_reg, b_rd_reg;

    logic [3:0]  k;
    logic [TOP_W-1:0] klast;
    val_t la_a, la_b, la_y;

    logic [LANES*32-1:0] in_row;
    val_t e_rd;

    tcfb_logadd u_la (.a(la_a), .b(la_b), .y(la_y));

    always_comb
    begin
        k = ktop_reg;
        if (k < 4'd2) k = 4'd2;
        if (k > 4'd8) k = 4'd8;
        klast = TOP_W'(k - 4'd1);
    end

    always_comb
    begin
        for (int t = 0; t < LANES; t++)
            in_row[t*32 +: 32] = in_val[t];
    end

    assign e_rd = e_row_reg[{i_reg, 5'd0} +: 32];

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_post = post_reg_v;

    // address of read word: forward reads j, backward reads j, posterior j
    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = {j_reg, i_reg};

    // target row of a message write
    logic [WORD_W-1:0] tgt_word;
    assign tgt_word = back_reg ? (j_reg - WORD_W'(1)) : (j_reg + WORD_W'(1));

    val_t fac;
    val_t xs;
    always_comb
    begin
        fac = sadd3(e_rd, prior_reg[i_reg], back_reg ? b_rd_reg : f_rd_reg);
        xs  = post_reg ? sadd(sadd3(e_rd, prior_reg[i_reg], f_rd_reg), b_rd_reg)
                       : fac;
    end

    // shared log-add operand select
    always_comb
    begin
        la_a = s_reg;
        la_b = post_reg ? x_reg[i_reg] : sadd(val_t'(sw_reg), x_reg[i_reg]);
        if (state_reg == ST_MSG)
            la_b = sadd(val_t'(st_reg), x_reg[i_reg]);
    end

    logic last_topic;
    assign last_topic = (i_reg == klast);

    // last forward step: source word is n-2
    logic fwd_done;
    assign fwd_done = (j_reg + WORD_W'(1) == WORD_W'(n_reg - CNT_W'(1)));

    // normalized posterior, saturated on the wide difference
    val_t post_diff;
    assign post_diff = sat32(34'(x_reg[i_reg]) - 34'(s_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_opcode && in_last) state_next = ST_INIT;
            ST_INIT:  if (last_topic) state_next = ST_LOAD2;
            ST_LOAD2: state_next = ST_LOAD;
            ST_LOAD:  state_next = last_topic ? ST_SUM : ST_LOAD2;
            ST_SUM:   if (last_topic) state_next = post_reg ? ST_POST : ST_MSG;
            ST_MSG:   if (last_topic) state_next = ST_LOAD2;
            ST_POST:  if (last_topic) state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_LOAD2;
            default:  state_next = ST_IDLE;
        endcase
        // sweep boundaries
        if (state_reg == ST_INIT && last_topic && n_reg == CNT_W'(1) && !back_reg)
            state_next = ST_INIT;
        if (state_reg == ST_MSG && last_topic && !back_reg && fwd_done)
            state_next = ST_INIT;
        if (state_reg == ST_OUT && out_ready && out_final)
            state_next = ST_IDLE;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_opcode && cnt_reg < CNT_W'(MAX_WORDS))
            emis_mem[cnt_reg[WORD_W-1:0]] <= in_row;
        if (state_reg == ST_INIT && !back_reg)
            fwd_mem[{WORD_W'(0), i_reg}] <= '0;
        if (state_reg == ST_INIT && back_reg)
            bwd_mem[{WORD_W'(n_reg - 1), i_reg}] <= '0;
        if (state_reg == ST_MSG && !back_reg)
            fwd_mem[{tgt_word, i_reg}] <= la_y;
        if (state_reg == ST_MSG && back_reg)
            bwd_mem[{tgt_word, i_reg}] <= la_y;
        e_row_reg <= emis_mem[j_reg];
        f_rd_reg  <= fwd_mem[rd_addr];
        b_rd_reg  <= bwd_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_opcode)
            prior_reg <= in_val;
        if (state_reg == ST_LOAD)
            x_reg[i_reg] <= xs;
        if (state_reg == ST_SUM) begin
            if (i_reg == '0)
                s_reg <= post_reg ? x_reg[0] : sadd(val_t'(sw_reg), x_reg[0]);
            else
                s_reg <= la_y;
        end
        if (state_reg == ST_POST) begin
            post_reg_v[i_reg] <= post_diff;
            if (i_reg == '0 || post_diff > best_val_reg) begin
                best_val_reg <= post_diff;
                best_reg     <= i_reg;
            end
            if (i_reg == '0)
                for (int t = 1; t < LANES; t++)
                    post_reg_v[t] <= 32'sh80000000;
        end
    end

    assign out_pos   = j_reg;
    assign out_best  = best_reg;
    assign out_final = (CNT_W'(j_reg) + CNT_W'(1) == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ktop_reg  <= 4'd8;
            sw_reg    <= -17'sd4350;
            st_reg    <= -17'sd124;
            cnt_reg   <= '0;
            n_reg     <= '0;
            back_reg  <= 1'b0;
            post_reg  <= 1'b0;
            j_reg     <= '0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOPICS: ktop_reg <= cfg_data[3:0];
                    REG_SWITCH: sw_reg   <= $signed(cfg_data);
                    REG_STAY:   st_reg   <= $signed(cfg_data);
                    default:    ;
                endcase
            end
            case (state_reg)
                ST_IDLE: if (in_valid) begin
                    if (!in_opcode)
                        cnt_reg <= '0;
                    else begin
                        if (in_last) begin
                            n_reg    <= (cnt_reg < CNT_W'(MAX_WORDS)) ? cnt_reg + 1'b1
                                                                       : cnt_reg;
                            cnt_reg  <= '0;
                            back_reg <= 1'b0;
                            post_reg <= 1'b0;
                            j_reg    <= '0;
                            i_reg    <= '0;
                        end else if (cnt_reg < CNT_W'(MAX_WORDS))
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_INIT: begin
                    i_reg <= last_topic ? '0 : i_reg + 1'b1;
                    if (last_topic) begin
                        // single word: no forward step, go straight to backward init
                        if (!back_reg && n_reg == CNT_W'(1))
                        begin
                            back_reg <= 1'b1;
                            j_reg    <= WORD_W'(n_reg - 1);
                        end
                        if (back_reg && n_reg == CNT_W'(1)) begin
                            post_reg <= 1'b1;
                            j_reg    <= '0;
                        end
                    end
                end
                ST_LOAD:  i_reg <= last_topic ? '0 : i_reg + 1'b1;
                ST_SUM:   i_reg <= last_topic ? '0 : i_reg + 1'b1;
                ST_POST:  i_reg <= last_topic ? '0 : i_reg + 1'b1;
                ST_MSG: begin
                    i_reg <= last_topic ? '0 : i_reg + 1'b1;
                    if (last_topic) begin
                        if (!back_reg)
                        begin
                            if (fwd_done)
                            begin
                                back_reg <= 1'b1;
                                j_reg    <= WORD_W'(n_reg - CNT_W'(1));
                            end
                            else
                                j_reg <= j_reg + 1'b1;
                        end
                        else if (j_reg == WORD_W'(1)) begin
                            post_reg <= 1'b1;
                            j_reg    <= '0;
                        end else
                            j_reg <= j_reg - 1'b1;
                    end
                end
                ST_OUT: if (out_ready) j_reg <= j_reg + 1'b1;
                default: ;
            endcase
        end
    end
endmodule

### hw/rtl/tcfb_checker.sv
// Port-level checker for the top level, bound in below
`include "topic_chain_forward_backward_assert.svh"
module tcfb_checker
    import tcfb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic final_result,
    input logic [TOP_W-1:0] best_topic
);
    // no input taken while results are pending
    `TCFB_ASSERT_IMP(a_excl, out_valid, !in_ready)
    // after the final beat is taken the block returns to accepting input
    `TCFB_ASSERT_NEXT(a_done, out_valid && out_ready && final_result, in_ready)
    // a stalled result holds
    `TCFB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(best_topic))
endmodule

bind topic_chain_forward_backward tcfb_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .final_result (out_ch.final_result),
    .best_topic   (out_ch.best_topic)
);
